// ===== rtl/core/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// bptc_pkg: shared types and constants of the pressure compensation block
// Field widths, pipeline depth, calibration register indexes and the
// control group that passes between the stall logic and the datapath.
// ----------------------------------------------------------------------------
package bptc_pkg;

  // field widths
  localparam int unsigned RawW   = 24;
  localparam int unsigned CalW   = 16;
  localparam int unsigned PressW = 32;
  localparam int unsigned TempW  = 20;

  // stream widths, padded to whole bytes
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 56;

  // configuration port
  localparam int unsigned CfgIdxW = 3;

  // pipeline depth, the last stage is the output register
  localparam int unsigned NumStages = 9;

  // temperature thresholds in hundredths of a degree
  localparam logic signed [TempW-1:0] TempRefCenti = 20'sd2000;
  localparam logic signed [TempW-1:0] TempLowCenti = -20'sd1500;

  // calibration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPressSens    = 3'd0,
    CfgPressOffset  = 3'd1,
    CfgSensTempCoef = 3'd2,
    CfgOffTempCoef  = 3'd3,
    CfgRefTemp      = 3'd4,
    CfgTempCoef     = 3'd5
  } cfg_reg_e;

  // per-stage load enables and valid flags
  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

endpackage

// ===== rtl/core/bptc_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// bptc_pipe_ctrl: valid and stall control of the compensation pipeline
// Each stage loads when it is empty or when the stage after it moves, so
// bubbles collapse and empty stages keep taking input while the output waits.
// ----------------------------------------------------------------------------
module bptc_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output bptc_pkg::pipe_ctrl_t ctrl_o
);
  import bptc_pkg::*;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  logic [NumStages-1:0] load;

  // load enables ripple back from the output
  always_comb begin
    load[NumStages-1] = ~valid_q[NumStages-1] | out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = ~valid_q[k] | load[k+1];
    end
  end

  // valid flags travel with the data
  always_comb begin
    valid_d[0] = load[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = load[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign ctrl_o.load  = load;
  assign ctrl_o.valid = valid_q;

endmodule

// ===== rtl/core/baro_pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation: second-order barometric compensation
// Nine-stage pipeline: one raw pressure and temperature pair in, one
// compensated pressure in pascals and temperature in 0.01 C out.
// ----------------------------------------------------------------------------
// A pair is accepted in every cycle unless the full pipeline is stalled, and
// passes the nine register stages: temperature difference, calibration
// products, first-order terms, squares, second-order terms, final offset
// and sensitivity, split pressure product, product sum, final subtract and
// saturate. A stalled output holds its result while empty stages upstream
// keep accepting pairs. The user must write the six calibration words over
// the cfg port while no pair is in flight (not enforced); they reset to zero.
module baro_pressure_temp_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [bptc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bptc_pkg::CalW-1:0]     cfg_data_i,
  // raw conversion pairs
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [bptc_pkg::InDataW-1:0]  s_axis_tdata,
  // compensated results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] pressure_pa, [51:32] temperature_centi, [55:52] zero
  output logic [bptc_pkg::OutDataW-1:0] m_axis_tdata
);
  import bptc_pkg::*;

  // calibration words
  logic [CalW-1:0] press_sens_q, press_off_q, sens_tc_q, off_tc_q, ref_temp_q, temp_coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_sens_q <= '0;
      press_off_q  <= '0;
      sens_tc_q    <= '0;
      off_tc_q     <= '0;
      ref_temp_q   <= '0;
      temp_coef_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgPressSens:    press_sens_q <= cfg_data_i;
        CfgPressOffset:  press_off_q  <= cfg_data_i;
        CfgSensTempCoef: sens_tc_q    <= cfg_data_i;
        CfgOffTempCoef:  off_tc_q     <= cfg_data_i;
        CfgRefTemp:      ref_temp_q   <= cfg_data_i;
        CfgTempCoef:     temp_coef_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stall and valid control
  pipe_ctrl_t ctrl;

  bptc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  assign s_axis_tready = ctrl.load[0];
  assign m_axis_tvalid = ctrl.valid[NumStages-1];

  // unpack the input transfer
  logic [RawW-1:0] raw_p, raw_t;
  assign raw_p = s_axis_tdata[RawW-1:0];
  assign raw_t = s_axis_tdata[2*RawW-1:RawW];

  // stage 1: temperature difference
  logic signed [24:0] dt_s1_q;
  logic [RawW-1:0]    d1_s1_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      dt_s1_q <= $signed({1'b0, raw_t}) - $signed({1'b0, ref_temp_q, 8'b0});
      d1_s1_q <= raw_p;
    end
  end

  // stage 2: calibration products and dT squared
  logic signed [41:0] prod_t_s2_q, prod_o_s2_q, prod_s_s2_q;
  logic signed [49:0] dtsq_s2_q;
  logic [RawW-1:0]    d1_s2_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[1]) begin
      prod_t_s2_q <= dt_s1_q * $signed({1'b0, temp_coef_q});
      prod_o_s2_q <= dt_s1_q * $signed({1'b0, off_tc_q});
      prod_s_s2_q <= dt_s1_q * $signed({1'b0, sens_tc_q});
      dtsq_s2_q   <= dt_s1_q * dt_s1_q;
      d1_s2_q     <= d1_s1_q;
    end
  end

  // stage 3: first-order temperature, offset and sensitivity
  logic signed [TempW-1:0] temp_s3_q;
  logic signed [41:0]      off_s3_q, sens_s3_q;
  logic [17:0]             t2_s3_q;
  logic [RawW-1:0]         d1_s3_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[2]) begin
      temp_s3_q <= TempRefCenti + $signed({prod_t_s2_q[41], prod_t_s2_q[41:23]});
      off_s3_q  <= $signed({10'b0, press_off_q, 16'b0})
                 + $signed({{7{prod_o_s2_q[41]}}, prod_o_s2_q[41:7]});
      sens_s3_q <= $signed({11'b0, press_sens_q, 15'b0})
                 + $signed({{8{prod_s_s2_q[41]}}, prod_s_s2_q[41:8]});
      t2_s3_q   <= dtsq_s2_q[48:31];
      d1_s3_q   <= d1_s2_q;
    end
  end

  // stage 4: squares of the distances to both thresholds
  logic signed [TempW-1:0] dist_ref, dist_low;
  assign dist_ref = temp_s3_q - TempRefCenti;
  assign dist_low = temp_s3_q - TempLowCenti;

  logic signed [39:0]      sq_ref_s4_q, sq_low_s4_q;
  logic                    lt_ref_s4_q, lt_low_s4_q;
  logic signed [TempW-1:0] temp_s4_q;
  logic signed [41:0]      off_s4_q, sens_s4_q;
  logic [17:0]             t2_s4_q;
  logic [RawW-1:0]         d1_s4_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[3]) begin
      sq_ref_s4_q <= dist_ref * dist_ref;
      sq_low_s4_q <= dist_low * dist_low;
      lt_ref_s4_q <= dist_ref[TempW-1];
      lt_low_s4_q <= dist_low[TempW-1];
      temp_s4_q   <= temp_s3_q;
      off_s4_q    <= off_s3_q;
      sens_s4_q   <= sens_s3_q;
      t2_s4_q     <= t2_s3_q;
      d1_s4_q     <= d1_s3_q;
    end
  end

  // stage 5: second-order corrections, final temperature
  logic [41:0] five_sq, seven_sq, eleven_sq, off2_d, sens2_d;

  always_comb begin
    five_sq   = {2'b0, sq_ref_s4_q} + {sq_ref_s4_q, 2'b0};
    seven_sq  = {sq_low_s4_q[38:0], 3'b0} - {2'b0, sq_low_s4_q};
    eleven_sq = {sq_low_s4_q[38:0], 3'b0} + {1'b0, sq_low_s4_q, 1'b0} + {2'b0, sq_low_s4_q};
    off2_d    = {1'b0, five_sq[41:1]};
    sens2_d   = {2'b0, five_sq[41:2]};
    // extra terms below -15 C
    if (lt_low_s4_q) begin
      off2_d  = off2_d + seven_sq;
      sens2_d = sens2_d + {1'b0, eleven_sq[41:1]};
    end
    // no correction at or above 20 C
    if (!lt_ref_s4_q) begin
      off2_d  = '0;
      sens2_d = '0;
    end
  end

  logic signed [TempW-1:0] temp_s5_q;
  logic signed [41:0]      off_s5_q, sens_s5_q;
  logic [41:0]             off2_s5_q, sens2_s5_q;
  logic [RawW-1:0]         d1_s5_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[4]) begin
      temp_s5_q  <= lt_ref_s4_q ? temp_s4_q - $signed({2'b0, t2_s4_q}) : temp_s4_q;
      off_s5_q   <= off_s4_q;
      sens_s5_q  <= sens_s4_q;
      off2_s5_q  <= off2_d;
      sens2_s5_q <= sens2_d;
      d1_s5_q    <= d1_s4_q;
    end
  end

  // stage 6: final offset and sensitivity
  logic signed [TempW-1:0] temp_s6_q;
  logic signed [41:0]      off_s6_q, sens_s6_q;
  logic [RawW-1:0]         d1_s6_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[5]) begin
      temp_s6_q <= temp_s5_q;
      off_s6_q  <= off_s5_q - $signed(off2_s5_q);
      sens_s6_q <= sens_s5_q - $signed(sens2_s5_q);
      d1_s6_q   <= d1_s5_q;
    end
  end

  // stage 7: raw pressure times sensitivity, split in two halves
  logic [44:0]             pp_lo_s7_q;
  logic signed [45:0]      pp_hi_s7_q;
  logic signed [TempW-1:0] temp_s7_q;
  logic signed [41:0]      off_s7_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[6]) begin
      pp_lo_s7_q <= d1_s6_q * sens_s6_q[20:0];
      pp_hi_s7_q <= $signed({1'b0, d1_s6_q}) * $signed(sens_s6_q[41:21]);
      temp_s7_q  <= temp_s6_q;
      off_s7_q   <= off_s6_q;
    end
  end

  // stage 8: product floored by 2^21, the low half only adds its carry-out bits
  logic signed [46:0]      prod_s8_q;
  logic signed [TempW-1:0] temp_s8_q;
  logic signed [41:0]      off_s8_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[7]) begin
      prod_s8_q <= pp_hi_s7_q + $signed({23'b0, pp_lo_s7_q[44:21]});
      temp_s8_q <= temp_s7_q;
      off_s8_q  <= off_s7_q;
    end
  end

  // stage 9: subtract offset, floor by 2^15, saturate to 32 bits
  logic signed [47:0] diff;
  logic               sat_hi, sat_lo;
  logic [PressW-1:0]  press_d;

  always_comb begin
    diff   = prod_s8_q - off_s8_q;
    // the shifted value fits 32 bits when its sign matches the top kept bit
    sat_hi = ~diff[47] & diff[PressW+14];
    sat_lo = diff[47] & ~diff[PressW+14];
    if (sat_hi) begin
      press_d = {1'b0, {(PressW-1){1'b1}}};
    end else if (sat_lo) begin
      press_d = {1'b1, {(PressW-1){1'b0}}};
    end else begin
      press_d = diff[PressW+14:15];
    end
  end

  logic [PressW-1:0] press_s9_q;
  logic [TempW-1:0]  temp_s9_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[8]) begin
      press_s9_q <= press_d;
      temp_s9_q  <= temp_s8_q;
    end
  end

  assign m_axis_tdata = {{(OutDataW-PressW-TempW){1'b0}}, temp_s9_q, press_s9_q};

endmodule
